FILE: src/pure_pursuit_heading_steer_macros.svh
// Assertion macros for the RTL files; only the job queue uses them.
`ifndef PURE_PURSUIT_HEADING_STEER_MACROS_SVH
`define PURE_PURSUIT_HEADING_STEER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed: forbidden condition seen");
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication broken");
`else
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/pphs_pkg.sv
package pphs_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [30:0] LA_RESET   = 31'd65536;
    localparam logic [15:0] GAIN_RESET = 16'd8192;

    // register indexes
    localparam logic CFG_LOOKAHEAD = 1'b0;
    localparam logic CFG_GAIN      = 1'b1;

    localparam int CW = 46;  // CORDIC datapath width

    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [31:0] robot_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               point_last;
    } t_in;

    typedef struct packed {
        logic signed [15:0] angular_rate;
        logic signed [15:0] yaw_err;
        logic               used_fallback;
    } t_out;

    // one path's worth of work for the back end
    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               fallback;
    } t_job;

    // arctan(2^-i) in Q.24
    function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
        logic signed [27:0] v;
        case (idx)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            5'd8:  v = 28'sd65536;
            5'd9:  v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/pphs_front.sv
module pphs_front import pphs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_req,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_full
);

    logic        r_s1_v, r_s2_v, r_s3_v;
    t_in         r_s1_req, r_s2_req, r_s3_req;
    logic [30:0] r_s1_ax, r_s1_ay, r_s1_az;
    logic        r_s1_huge, r_s2_huge;
    logic [61:0] r_s2_sx, r_s2_sy, r_s2_sz;
    logic        r_s3_reach;
    logic [30:0] r_la;
    logic [61:0] r_la_sq;
    logic        r_found;
    logic signed [31:0] r_tx, r_ty;

    logic        en;
    logic signed [32:0] dx, dy, dz;
    logic [32:0] ax, ay, az;
    logic [63:0] sum;
    logic signed [31:0] tx_eff, ty_eff;
    logic        found_n;

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    assign en      = !(r_s3_v && r_s3_req.point_last && i_full);
    assign o_ready = en;

    always_comb begin
        dx = {i_req.point_x[31], i_req.point_x} - {i_req.robot_x[31], i_req.robot_x};
        dy = {i_req.point_y[31], i_req.point_y} - {i_req.robot_y[31], i_req.robot_y};
        dz = {i_req.point_z[31], i_req.point_z} - {i_req.robot_z[31], i_req.robot_z};
        ax = abs33(dx);
        ay = abs33(dy);
        az = abs33(dz);
        sum = 64'(r_s2_sx) + 64'(r_s2_sy) + 64'(r_s2_sz);
    end

    always_comb begin
        tx_eff  = r_found ? r_tx : r_s3_req.point_x;
        ty_eff  = r_found ? r_ty : r_s3_req.point_y;
        found_n = r_found | r_s3_reach;
        o_push  = r_s3_v && r_s3_req.point_last && !i_full;
        o_job.qx = r_s3_req.quat_x;
        o_job.qy = r_s3_req.quat_y;
        o_job.qz = r_s3_req.quat_z;
        o_job.qw = r_s3_req.quat_w;
        o_job.dx = {tx_eff[31], tx_eff} - {r_s3_req.robot_x[31], r_s3_req.robot_x};
        o_job.dy = {ty_eff[31], ty_eff} - {r_s3_req.robot_y[31], r_s3_req.robot_y};
        o_job.fallback = !found_n;
    end

    always_ff @(posedge i_clk) begin
        r_la_sq <= r_la * r_la;
        if (en) begin
            r_s1_req  <= i_req;
            r_s1_ax   <= ax[30:0];
            r_s1_ay   <= ay[30:0];
            r_s1_az   <= az[30:0];
            r_s1_huge <= (|ax[32:31]) | (|ay[32:31]) | (|az[32:31]);
            r_s2_req  <= r_s1_req;
            r_s2_sx   <= r_s1_ax * r_s1_ax;
            r_s2_sy   <= r_s1_ay * r_s1_ay;
            r_s2_sz   <= r_s1_az * r_s1_az;
            r_s2_huge <= r_s1_huge;
            r_s3_req  <= r_s2_req;
            r_s3_reach <= r_s2_huge || (sum >= 64'(r_la_sq));
        end
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_found <= 1'b0;
            r_tx    <= '0;
            r_ty    <= '0;
            r_la    <= LA_RESET;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_LOOKAHEAD) begin
                r_la <= i_cfg_data;
            end
            if (en) begin
                r_s1_v <= i_valid;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
                if (r_s3_v) begin
                    // latch the candidate while still searching
                    if (!r_found) begin
                        r_tx <= r_s3_req.point_x;
                        r_ty <= r_s3_req.point_y;
                    end
                    r_found <= r_s3_req.point_last ? 1'b0 : found_n;
                end
            end
        end
    end

endmodule

FILE: src/pphs_queue.sv
`include "pure_pursuit_heading_steer_macros.svh"
module pphs_queue import pphs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_job           r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CNW-1:0] r_count;

    assign o_full  = (r_count == CNW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= nxt(r_wr);
            end
            if (i_pop) begin
                r_rd <= nxt(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNW'(DEPTH))

endmodule

FILE: src/pphs_back.sv
module pphs_back import pphs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_rsp
);

    localparam int SW = $clog2(CORDIC_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PROD, ST_SUMY, ST_NORM, ST_ITER, ST_WRAP, ST_GAIN, ST_OUT
    } t_state;

    t_state r_state;
    t_job   r_job;
    logic [15:0] r_gain;
    logic signed [31:0] r_pww, r_pxx, r_pyy, r_pzz, r_pwz, r_pxy;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [27:0] r_z;
    logic [SW-1:0] r_step;
    logic r_bear;
    logic signed [16:0] r_yaw, r_brg;
    logic signed [15:0] r_err;
    logic signed [32:0] r_prod;
    logic r_o_valid;
    t_out r_o_rsp;

    logic [CW-1:0] amx, amy;
    logic at_lim, is_zero, step_done;
    logic signed [CW-1:0] sx, sy;
    logic signed [27:0] z_next, z_fin;
    logic signed [27:0] z_rnd;
    logic signed [16:0] ang;
    logic signed [17:0] wv;
    logic signed [20:0] rate_w;
    logic signed [15:0] rate_sat;

    always_comb begin
        amx = r_cx[CW-1] ? CW'(-r_cx) : CW'(r_cx);
        amy = r_cy[CW-1] ? CW'(-r_cy) : CW'(r_cy);
        at_lim  = (|amx[CW-1:40]) | (|amy[CW-1:40]);
        is_zero = (r_cx == '0) && (r_cy == '0);
        sx = r_cy >>> r_step;
        sy = r_cx >>> r_step;
        z_next = (r_cy > 0) ? r_z + atan_q24(5'(r_step)) : r_z - atan_q24(5'(r_step));
        step_done = (r_step == SW'(CORDIC_STEPS - 1));
        z_fin = is_zero ? 28'sd0 : z_next;
        z_rnd = z_fin + 28'sd1024;
        ang   = is_zero ? 17'sd0 : z_rnd[27:11];
        // wrap bearing minus yaw into [-pi, pi)
        wv = 18'(r_brg) - 18'(r_yaw) + PI_Q13;
        if (wv < 0) begin
            wv = wv + TWO_PI_Q13;
        end else if (wv >= TWO_PI_Q13) begin
            wv = wv - TWO_PI_Q13;
        end
        wv = wv - PI_Q13;
        rate_w = 21'((r_prod + 33'sd4096) >>> 13);
        if (rate_w > 21'sd32767) begin
            rate_sat = 16'sh7fff;
        end else if (rate_w < -21'sd32768) begin
            rate_sat = 16'sh8000;
        end else begin
            rate_sat = rate_w[15:0];
        end
    end

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = r_o_valid;
    assign o_rsp   = r_o_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_gain    <= GAIN_RESET;
            r_bear    <= 1'b0;
            r_step    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_GAIN) begin
                r_gain <= i_cfg_data;
            end
            if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    r_pww <= r_job.qw * r_job.qw;
                    r_pxx <= r_job.qx * r_job.qx;
                    r_pyy <= r_job.qy * r_job.qy;
                    r_pzz <= r_job.qz * r_job.qz;
                    r_pwz <= r_job.qw * r_job.qz;
                    r_pxy <= r_job.qx * r_job.qy;
                    r_state <= ST_SUMY;
                end
                ST_SUMY: begin
                    r_cy <= (CW'(r_pwz) + CW'(r_pxy)) <<< 1;
                    r_cx <= CW'(r_pww) + CW'(r_pxx) - CW'(r_pyy) - CW'(r_pzz);
                    r_bear  <= 1'b0;
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    r_step <= '0;
                    if (is_zero) begin
                        r_state <= ST_ITER;
                    end else if (!at_lim) begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end else begin
                        // fold the left half plane onto the right
                        if (r_cx < 0) begin
                            if (r_cy >= 0) begin
                                r_cx <= r_cy;
                                r_cy <= -r_cx;
                                r_z  <= HALF_PI_Q24;
                            end else begin
                                r_cx <= -r_cy;
                                r_cy <= r_cx;
                                r_z  <= -HALF_PI_Q24;
                            end
                        end else begin
                            r_z <= '0;
                        end
                        r_state <= ST_ITER;
                    end
                end
                ST_ITER: begin
                    if (!is_zero) begin
                        if (r_cy > 0) begin
                            r_cx <= r_cx + sx;
                            r_cy <= r_cy - sy;
                        end else begin
                            r_cx <= r_cx - sx;
                            r_cy <= r_cy + sy;
                        end
                        r_z    <= z_next;
                        r_step <= r_step + 1'b1;
                    end
                    if (is_zero || step_done) begin
                        if (!r_bear) begin
                            r_yaw  <= ang;
                            r_bear <= 1'b1;
                            r_cx   <= CW'(r_job.dx);
                            r_cy   <= CW'(r_job.dy);
                            r_state <= ST_NORM;
                        end else begin
                            r_brg   <= ang;
                            r_state <= ST_WRAP;
                        end
                    end
                end
                ST_WRAP: begin
                    r_err   <= wv[15:0];
                    r_state <= ST_GAIN;
                end
                ST_GAIN: begin
                    r_prod  <= $signed({1'b0, r_gain}) * r_err;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_rsp.angular_rate  <= rate_sat;
                        r_o_rsp.yaw_err       <= r_err;
                        r_o_rsp.used_fallback <= r_job.fallback;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/pure_pursuit_heading_steer.sv
// Pure-pursuit steering: path points stream in at one request per cycle, each
// with the robot pose. A three-stage front pipeline squares the 3D offset and
// picks the first point at or beyond the lookahead radius (the last point if
// none). Requests are taken one per cycle, except that the front holds ready low
// while the path-end request waits for room in the job queue. On the request
// marked last, a job goes to a short queue; the back end then works it with one
// shared iterative CORDIC unit: yaw from the quaternion, then bearing to the
// target, each a normalization phase followed by CORDIC_STEPS steps. The front
// keeps taking the next path while the back end works or waits on a stalled
// response. The response carries gain times wrapped heading error, saturated
// to 16 bits.
module pure_pursuit_heading_steer import pphs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    // handoff between front and back
    logic q_push, q_full, q_pop, q_empty;
    t_job q_in, q_out;

    pphs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (q_push),
        .o_job      (q_in),
        .i_full     (q_full)
    );

    pphs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    // gain register is 16 bits: take the low part of the write data
    pphs_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data[15:0]),
        .i_empty    (q_empty),
        .i_job      (q_out),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp)
    );

endmodule

FILE: verif/tb_pure_pursuit_heading_steer.sv
// Self-checking bench for the pure-pursuit heading steer block: directed
// corner paths, then random paths under several lookahead and gain settings,
// with bursty requests, stalling responses and one long response hold-off.
module tb_pure_pursuit_heading_steer;
    import pphs_pkg::*;

    localparam int    STEPS      = 16;
    localparam int    DRAIN_WAIT = 200;
    localparam int    IDLE_LIMIT = 20000;   // cycles with no handshake before giving up
    localparam int    RAND_ITEMS = 900;
    localparam longint NORM_MIN  = 64'd1099511627776;  // 2^40
    localparam longint PI_Q      = 25736;
    localparam longint TWO_PI_Q  = 51472;
    localparam longint QUAD_Q24  = 26353589;

    // arctan(2^-i) in Q.24
    localparam longint ATAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct {
        t_in  req;
        bit   typed;
        t_out rsp;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_req = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_LOOKAHEAD;
    logic [30:0] i_cfg_data = '0;

    // predictor copy of registers and path state
    logic [30:0] la_dist = LA_RESET;
    logic [15:0] gain = GAIN_RESET;
    bit          tgt_found;
    longint      tgt_x, tgt_y;

    t_out        rsp_expect_q[$];
    dir_row_t    dir_tab[$];
    int          errors = 0;
    int          rsp_seen = 0;
    int          paths_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    pure_pursuit_heading_steer dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    // CORDIC vectoring atan2, Q3.13 out
    function automatic longint atan2_q13(longint y, longint x);
        longint ax, ay, m, cx, cy, z, t, dx, dy;
        ax = magn(x);
        ay = magn(y);
        z = 0;
        if (ax == 0 && ay == 0) return 0;
        m = ax > ay ? ax : ay;
        while (m < NORM_MIN) begin
            ax = ax <<< 1;
            ay = ay <<< 1;
            m = m <<< 1;
        end
        cx = x < 0 ? -ax : ax;
        cy = y < 0 ? -ay : ay;
        // fold the left half-plane into the right one
        if (cx < 0) begin
            t = cx;
            if (cy >= 0) begin
                cx = cy; cy = -t; z = QUAD_Q24;
            end else begin
                cx = -cy; cy = t; z = -QUAD_Q24;
            end
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx += dx; cy -= dy; z += ATAN_Q24[i];
            end else begin
                cx -= dx; cy += dy; z -= ATAN_Q24[i];
            end
        end
        return (z + 1024) >>> 11;
    endfunction

    function automatic bit beyond_lookahead(longint dx, longint dy, longint dz);
        longint unsigned ax, ay, az, lim, r;
        ax = magn(dx);
        ay = magn(dy);
        az = magn(dz);
        lim = 64'd1 << 31;
        if (ax >= lim || ay >= lim || az >= lim) return 1'b1;
        r = la_dist;
        return ax * ax + ay * ay + az * az >= r * r;
    endfunction

    // advance path state by one request; return 1 with the response on path end
    function automatic bit pursuit_step(t_in r, output t_out rsp);
        longint qx, qy, qz, qw, yaw, bearing, err, rate;
        if (!tgt_found) begin
            tgt_x = r.point_x;
            tgt_y = r.point_y;
            if (beyond_lookahead(longint'(r.point_x) - r.robot_x,
                                 longint'(r.point_y) - r.robot_y,
                                 longint'(r.point_z) - r.robot_z))
                tgt_found = 1'b1;
        end
        rsp = '0;
        if (!r.point_last) return 1'b0;
        qx = r.quat_x; qy = r.quat_y; qz = r.quat_z; qw = r.quat_w;
        yaw = atan2_q13(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
        bearing = atan2_q13(tgt_y - r.robot_y, tgt_x - r.robot_x);
        err = (bearing - yaw + PI_Q) % TWO_PI_Q;
        if (err < 0) err += TWO_PI_Q;
        err -= PI_Q;
        rate = (longint'(gain) * err + 4096) >>> 13;
        if (rate > 32767) rate = 32767;
        if (rate < -32768) rate = -32768;
        rsp.angular_rate = rate[15:0];
        rsp.yaw_err = err[15:0];
        rsp.used_fallback = !tgt_found;
        tgt_found = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_in mk_req(longint rx, longint ry, longint rz,
                                   longint qx, longint qy, longint qz, longint qw,
                                   longint px, longint py, longint pz, bit last);
        t_in r;
        r.robot_x = rx[31:0]; r.robot_y = ry[31:0]; r.robot_z = rz[31:0];
        r.quat_x = qx[15:0]; r.quat_y = qy[15:0]; r.quat_z = qz[15:0];
        r.quat_w = qw[15:0];
        r.point_x = px[31:0]; r.point_y = py[31:0]; r.point_z = pz[31:0];
        r.point_last = last;
        return r;
    endfunction

    function automatic longint rand_quat();
        return longint'($urandom_range(32768)) - 16384;
    endfunction

    function automatic longint rand_coord(longint span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // random request: mostly near the robot so both sides of the lookahead show up
    function automatic t_in rand_req(bit last);
        t_in    r;
        longint span, rx, ry, rz;
        span = 64'd1 << $urandom_range(10, 20);
        if ($urandom_range(3) == 0) begin
            rx = $signed($urandom); ry = $signed($urandom); rz = $signed($urandom);
        end else begin
            rx = rand_coord(1 << 20); ry = rand_coord(1 << 20); rz = rand_coord(1 << 20);
        end
        r = mk_req(rx, ry, rz, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                   rx + rand_coord(span), ry + rand_coord(span), rz + rand_coord(span),
                   last);
        if ($urandom_range(7) == 0) begin
            r.point_x = $urandom; r.point_y = $urandom; r.point_z = $urandom;
        end
        if ($urandom_range(15) == 0) begin
            r.quat_x = '0; r.quat_y = '0; r.quat_z = '0; r.quat_w = '0;
        end
        return r;
    endfunction

    // offer one request, hold it until taken, then predict
    task automatic send_req(t_in r, bit typed, t_out typed_rsp);
        int   gap;
        t_out rsp;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk) i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        if (pursuit_step(r, rsp)) begin
            rsp_expect_q.push_back(typed ? typed_rsp : rsp);
            paths_sent++;
        end
    endtask

    // drain, let the back end settle, then write a register
    task automatic write_cfg(logic idx, logic [30:0] val);
        @(negedge i_clk) i_valid <= 1'b0;
        wait (rsp_expect_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        if (idx == CFG_LOOKAHEAD) la_dist = val;
        else gain = val[15:0];
    endtask

    task automatic random_paths(int count);
        int n, plen;
        n = 0;
        while (n < count) begin
            plen = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
            for (int k = 0; k < plen; k++) begin
                send_req(rand_req(k == plen - 1), 1'b0, '0);
                n++;
            end
        end
    endtask

    // receiver: hold off long right after reset, then stall in patterns
    initial begin
        int stretch, mode;
        @(posedge i_rst_n);
        repeat (500) @(negedge i_clk) i_ready <= 1'b0;
        forever begin
            stretch = $urandom_range(20, 200);
            mode = $urandom_range(2);
            repeat (stretch) begin
                @(negedge i_clk);
                case (mode)
                    0: begin
                        i_ready <= 1'b1;
                    end
                    1: begin
                        i_ready <= $urandom_range(1);
                    end
                    default: begin
                        i_ready <= ($urandom_range(3) == 0);
                    end
                endcase
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            rsp_seen++;
            if (rsp_expect_q.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                errors++;
            end else begin
                want = rsp_expect_q.pop_front();
                if (o_rsp.angular_rate !== want.angular_rate) begin
                    $display("%0t: angular_rate expected %0d actual %0d", $time,
                             want.angular_rate, o_rsp.angular_rate);
                    errors++;
                end
                if (o_rsp.yaw_err !== want.yaw_err) begin
                    $display("%0t: yaw_err expected %0d actual %0d", $time,
                             want.yaw_err, o_rsp.yaw_err);
                    errors++;
                end
                if (o_rsp.used_fallback !== want.used_fallback) begin
                    $display("%0t: used_fallback expected %0b actual %0b", $time,
                             want.used_fallback, o_rsp.used_fallback);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        localparam longint M = 65536;
        localparam longint HQ = 11585;   // 0.707 in Q1.14
        t_out z_fb;
        z_fb = '0;
        z_fb.used_fallback = 1'b1;

        // zero vectors: zero quaternion, and a pitch of ninety degrees, target on robot
        dir_tab.push_back('{mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, z_fb});
        dir_tab.push_back('{mk_req(5*M, -3*M, M, 0, HQ, 0, HQ, 5*M, -3*M, M, 1),
                            1'b1, z_fb});
        // huge offsets at the coordinate extremes
        dir_tab.push_back('{mk_req(2147483647, 2147483647, 2147483647, 0, 0, 0, 16384,
                                   -2147483648, -2147483648, -2147483648, 1), 1'b0, '0});
        dir_tab.push_back('{mk_req(-2147483648, -2147483648, -2147483648, -16384, 0, 0, 0,
                                   2147483647, 2147483647, 2147483647, 1), 1'b0, '0});
        // near, far, farther: first far point wins
        dir_tab.push_back('{mk_req(0, 0, 0, 0, 0, 0, 16384, M/2, 0, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk_req(0, 0, 0, 0, 0, 0, 16384, 3*M, M, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk_req(0, 0, 0, 0, 0, 0, 16384, 10*M, -9*M, 0, 1), 1'b0, '0});
        // all near: fall back to the last point, pose changes per request
        dir_tab.push_back('{mk_req(M, M, 0, 0, 0, HQ, HQ, M, M + M/4, 0, 0), 1'b0, '0});
        dir_tab.push_back('{mk_req(2*M, M, 0, 0, 0, HQ, HQ, 2*M, M/2, M/4, 0), 1'b0, '0});
        dir_tab.push_back('{mk_req(M, 0, M, 0, 0, -HQ, HQ, M/2, -M/2, M, 1), 1'b0, '0});
        // exactly on the lookahead radius
        dir_tab.push_back('{mk_req(0, 0, 0, 0, 0, 0, 16384, 0, 0, M, 1), 1'b0, '0});
        // target behind the robot: wrap around pi
        dir_tab.push_back('{mk_req(0, 0, 0, 0, 0, 16384, 0, -2*M, 1, 0, 1), 1'b0, '0});
        dir_tab.push_back('{mk_req(0, 0, 0, 0, 0, 16384, 16384, -2*M, -1, 0, 1), 1'b0, '0});
        // quaternion extremes
        dir_tab.push_back('{mk_req(0, 0, 0, -16384, -16384, -16384, -16384, M, 3*M, 0, 1),
                            1'b0, '0});
        dir_tab.push_back('{mk_req(0, 0, 0, 16384, 16384, 16384, 16384, -3*M, -M, 0, 1),
                            1'b0, '0});
        dir_tab.push_back('{mk_req(0, 0, 0, 16384, -16384, 0, 0, -M, -4*M, 2*M, 1),
                            1'b0, '0});

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
        random_paths(RAND_ITEMS / 4);

        // zero radius and zero gain
        write_cfg(CFG_LOOKAHEAD, '0);
        write_cfg(CFG_GAIN, 31'd0);
        random_paths(RAND_ITEMS / 4);

        // widest radius and largest gain: saturation and fallback
        write_cfg(CFG_LOOKAHEAD, 31'h7FFF_FFFF);
        write_cfg(CFG_GAIN, 31'd65535);
        random_paths(RAND_ITEMS / 4);

        write_cfg(CFG_LOOKAHEAD, 31'($urandom_range(1 << 21)));
        write_cfg(CFG_GAIN, 31'($urandom_range(65535)));
        random_paths(RAND_ITEMS / 4);

        @(negedge i_clk) i_valid <= 1'b0;
        wait (rsp_expect_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d paths over four register settings, %0d responses checked.",
                 paths_sent, rsp_seen);
        if (errors == 0 && rsp_expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/pphs_pkg.sv
src/pphs_front.sv
src/pphs_queue.sv
src/pphs_back.sv
src/pure_pursuit_heading_steer.sv
verif/tb_pure_pursuit_heading_steer.sv
